[rtl/chm_pkg.sv]
// shared constants and types for the chained hash map
package chm_pkg;

  localparam int MAX_BUCKETS_DEF = 256;
  localparam int NODE_POOL_DEF   = 256;
  localparam int DATA_BITS_DEF   = 32;
  localparam int KEY_BITS        = 31;
  localparam int CNT_BITS        = 9;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_UNUSED = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_HEAD_RD,
    S_HEAD_WAIT,
    S_NODE_RD,
    S_NODE_WAIT,
    S_FREE_RD,
    S_FREE_WAIT,
    S_COMMIT,
    S_DONE
  } state_t;

endpackage

[rtl/chm_mod.sv]
// restoring remainder unit, one quotient bit per cycle
module chm_mod #(
  parameter int NUM_BITS = 31,
  parameter int DEN_BITS = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                done,
  output logic [DEN_BITS-1:0] rem
);

  localparam int CW = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] shreg;
  logic [DEN_BITS:0]   part;
  logic [DEN_BITS-1:0] dreg;
  logic [CW-1:0]       left;
  logic                run;
  logic [DEN_BITS+1:0] trial;
  logic [DEN_BITS+1:0] diff;

  // shift in next numerator bit and try subtracting
  always_comb begin
    trial = {part, shreg[NUM_BITS-1]};
    diff  = trial - {2'b00, dreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= run && !go && (left == CW'(1));
      if (go) begin
        run   <= 1'b1;
        left  <= CW'(NUM_BITS);
        shreg <= num;
        part  <= '0;
        dreg  <= den;
      end else if (run) begin
        shreg <= shreg << 1;
        if (!diff[DEN_BITS+1]) part <= diff[DEN_BITS:0];
        else part <= trial[DEN_BITS:0];
        left <= left - CW'(1);
        if (left == CW'(1)) run <= 1'b0;
      end
    end
  end

  assign rem = part[DEN_BITS-1:0];

endmodule

[rtl/chm_store.sv]
// bucket head memory and node memory, registered reads
module chm_store #(
  parameter int BW = 8,
  parameter int PW = 9,
  parameter int KW = 31,
  parameter int DW = 32,
  parameter int MAX_BUCKETS = 256,
  parameter int NODE_POOL = 256
) (
  input  logic          clk,
  input  logic [BW-1:0] head_raddr,
  output logic [PW-1:0] head_rdata,
  output logic          head_rvalid,
  input  logic          head_we,
  input  logic [BW-1:0] head_waddr,
  input  logic [PW-1:0] head_wdata,
  input  logic          rst,
  input  logic [PW-2:0] node_raddr,
  output logic [KW-1:0] node_rkey,
  output logic [DW-1:0] node_rdata,
  output logic [PW-1:0] node_rlink,
  input  logic          key_we,
  input  logic          link_we,
  input  logic [PW-2:0] node_waddr,
  input  logic [KW-1:0] node_wkey,
  input  logic [DW-1:0] node_wdata,
  input  logic [PW-1:0] node_wlink
);

  logic [PW-1:0] head_mem [MAX_BUCKETS];
  logic          head_vld [MAX_BUCKETS];
  logic [KW-1:0] key_mem  [NODE_POOL];
  logic [DW-1:0] data_mem [NODE_POOL];
  logic [PW-1:0] link_mem [NODE_POOL];

  // bucket heads with valid bits cleared at reset
  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    head_rdata  <= head_mem[head_raddr];
    head_rvalid <= head_vld[head_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_BUCKETS; i++) head_vld[i] <= 1'b0;
    end else if (head_we) begin
      head_vld[head_waddr] <= 1'b1;
    end
  end

  // node pool
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[node_waddr]  <= node_wkey;
      data_mem[node_waddr] <= node_wdata;
    end
    if (link_we) link_mem[node_waddr] <= node_wlink;
    node_rkey  <= key_mem[node_raddr];
    node_rdata <= data_mem[node_raddr];
    node_rlink <= link_mem[node_raddr];
  end

endmodule

[rtl/chained_hash_map_top.sv]
// top level of the chained hash map: request sequencer
//
// Usage: pulse start with req_type, key and data_in while busy is low;
// the request is taken at that edge and busy rises. One result comes
// back per request: status, data_out and live_entries are valid for
// exactly one cycle while done is high; the receiver cannot stall.
// Requests: insert (0), delete (1), search (2); code 3 reports not found.
// Sequence: the bit-serial divider forms the bucket remainder, then the
// bucket head is read, each chain node visited is read in turn, a walk
// that misses ends at the end of the chain, an insert that pops the
// free list reads the free node, then commit and result.
// The divider and the single node memory read port set the time per
// request. A new request may start the cycle after done.
// bucket_cfg writes bucket_count when bucket_cfg_we is high; the user
// must do so only while idle, the block does not enforce it. Reset
// empties all buckets (valid bits on the head memory), clears the free
// list, allocation pointer and live count, and sets the bucket count to 256.
module chained_hash_map_top #(
  parameter int MAX_BUCKETS = chm_pkg::MAX_BUCKETS_DEF,
  parameter int NODE_POOL   = chm_pkg::NODE_POOL_DEF,
  parameter int DATA_BITS   = chm_pkg::DATA_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   req_type,
  input  logic [chm_pkg::KEY_BITS-1:0] key,
  input  logic [DATA_BITS-1:0]         data_in,
  input  logic                         bucket_cfg_we,
  input  logic [chm_pkg::CNT_BITS-1:0] bucket_cfg,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [DATA_BITS-1:0]         data_out,
  output logic [chm_pkg::CNT_BITS-1:0] live_entries
);

  localparam int KW = chm_pkg::KEY_BITS;
  localparam int CW = chm_pkg::CNT_BITS;
  localparam int PW = $clog2(NODE_POOL) + 1;
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int MW = $clog2(MAX_BUCKETS + 1);
  localparam int SW = $clog2(NODE_POOL + 1);
  localparam logic [PW-1:0] NIL = PW'(NODE_POOL);

  chm_pkg::state_t state, state_next;

  logic [CW-1:0]        bcount;
  logic [1:0]           rq;
  logic [KW-1:0]        rkey;
  logic [DATA_BITS-1:0] rdata;
  logic [BW-1:0]        bucket;
  logic [PW-1:0]        cur, prev, hit, hit_link, head_val, alloc;
  logic [PW-1:0]        free_head, never_used;
  logic [CW-1:0]        total;
  logic [SW-1:0]        steps;
  logic                 mod_go, mod_done;
  logic [MW-1:0]        den;
  logic [MW-1:0]        rem;
  logic [DATA_BITS-1:0] found_data;
  logic                 found;

  logic [PW-1:0]        head_rdata, node_rlink;
  logic                 head_rvalid;
  logic [KW-1:0]        node_rkey;
  logic [DATA_BITS-1:0] node_rdata;
  logic                 head_we, key_we, link_we;
  logic [BW-1:0]        head_raddr, head_waddr;
  logic [PW-1:0]        head_wdata, node_wlink;
  logic [PW-2:0]        node_raddr, node_waddr;

  // effective bucket count, clamped to 1..MAX_BUCKETS
  always_comb begin
    if (bcount == '0) den = MW'(1);
    else if ({23'd0, bcount} > 32'(MAX_BUCKETS)) den = MW'(MAX_BUCKETS);
    else den = MW'(bcount);
  end

  chm_mod #(.NUM_BITS(KW), .DEN_BITS(MW)) u_mod (
    .clk(clk), .rst(rst), .go(mod_go), .num(rkey), .den(den),
    .done(mod_done), .rem(rem)
  );

  chm_store #(
    .BW(BW), .PW(PW), .KW(KW), .DW(DATA_BITS),
    .MAX_BUCKETS(MAX_BUCKETS), .NODE_POOL(NODE_POOL)
  ) u_store (
    .clk(clk), .rst(rst),
    .head_raddr(head_raddr), .head_rdata(head_rdata), .head_rvalid(head_rvalid),
    .head_we(head_we), .head_waddr(head_waddr), .head_wdata(head_wdata),
    .node_raddr(node_raddr), .node_rkey(node_rkey), .node_rdata(node_rdata),
    .node_rlink(node_rlink), .key_we(key_we), .link_we(link_we),
    .node_waddr(node_waddr), .node_wkey(rkey), .node_wdata(rdata),
    .node_wlink(node_wlink)
  );

  assign head_val = head_rvalid ? head_rdata : NIL;
  assign busy     = (state != chm_pkg::S_IDLE);
  assign mod_go   = (state == chm_pkg::S_MOD) && !mod_done && (steps == '0);

  // next state and memory controls
  always_comb begin
    state_next = state;
    head_raddr = bucket;
    node_raddr = cur[PW-2:0];
    head_we    = 1'b0;
    head_waddr = bucket;
    head_wdata = hit_link;
    key_we     = 1'b0;
    link_we    = 1'b0;
    node_waddr = hit[PW-2:0];
    node_wlink = free_head;
    unique case (state)
      chm_pkg::S_IDLE: if (start) state_next = chm_pkg::S_MOD;
      chm_pkg::S_MOD: if (mod_done) state_next = chm_pkg::S_HEAD_RD;
      chm_pkg::S_HEAD_RD: state_next = chm_pkg::S_HEAD_WAIT;
      chm_pkg::S_HEAD_WAIT: state_next = chm_pkg::S_NODE_RD;
      chm_pkg::S_NODE_RD: begin
        if (cur >= NIL || steps == SW'(NODE_POOL)) begin
          if (rq == chm_pkg::REQ_INSERT && free_head < NIL)
            state_next = chm_pkg::S_FREE_RD;
          else
            state_next = chm_pkg::S_COMMIT;
        end else begin
          state_next = chm_pkg::S_NODE_WAIT;
        end
      end
      chm_pkg::S_NODE_WAIT: begin
        if (node_rkey == rkey) state_next = chm_pkg::S_COMMIT;
        else state_next = chm_pkg::S_NODE_RD;
      end
      chm_pkg::S_FREE_RD: begin
        node_raddr = free_head[PW-2:0];
        state_next = chm_pkg::S_FREE_WAIT;
      end
      // keep the free node link on the read port through commit
      chm_pkg::S_FREE_WAIT: begin
        node_raddr = free_head[PW-2:0];
        state_next = chm_pkg::S_COMMIT;
      end
      chm_pkg::S_COMMIT: begin
        if (rq == chm_pkg::REQ_INSERT && !found && alloc < NIL) begin
          key_we     = 1'b1;
          link_we    = 1'b1;
          node_waddr = alloc[PW-2:0];
          node_wlink = head_val;
          head_we    = 1'b1;
          head_wdata = alloc;
        end else if (rq == chm_pkg::REQ_DELETE && found) begin
          // unlink from predecessor or head, hit goes back to free list
          if (prev < NIL) begin
            link_we    = 1'b1;
            node_waddr = prev[PW-2:0];
            node_wlink = hit_link;
          end else begin
            head_we = 1'b1;
          end
        end
        state_next = chm_pkg::S_DONE;
      end
      chm_pkg::S_DONE: begin
        if (rq == chm_pkg::REQ_DELETE && found) begin
          link_we    = 1'b1;
          node_waddr = hit[PW-2:0];
          node_wlink = free_head;
        end
        state_next = chm_pkg::S_IDLE;
      end
      default: state_next = chm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= chm_pkg::S_IDLE;
    else state <= state_next;
  end

  // request registers and chain walk
  always_ff @(posedge clk) begin
    if (rst) begin
      bcount     <= CW'(256);
      free_head  <= NIL;
      never_used <= '0;
      total      <= '0;
      done       <= 1'b0;
      steps      <= '0;
    end else begin
      done <= (state == chm_pkg::S_COMMIT);
      if (bucket_cfg_we) bcount <= bucket_cfg;
      unique case (state)
        chm_pkg::S_IDLE: if (start) begin
          rq    <= req_type;
          rkey  <= key;
          rdata <= data_in;
          found <= 1'b0;
          steps <= '0;
          prev  <= NIL;
        end
        chm_pkg::S_MOD: begin
          steps <= mod_done ? '0 : SW'(1);
          if (mod_done) bucket <= BW'(rem);
        end
        chm_pkg::S_HEAD_WAIT: cur <= head_val;
        chm_pkg::S_NODE_RD: begin
          alloc <= (never_used < NIL) ? never_used : NIL;
        end
        chm_pkg::S_NODE_WAIT: begin
          steps <= steps + SW'(1);
          if (node_rkey == rkey) begin
            found      <= 1'b1;
            hit        <= cur;
            hit_link   <= node_rlink;
            found_data <= node_rdata;
          end else begin
            prev <= cur;
            cur  <= node_rlink;
          end
        end
        chm_pkg::S_FREE_WAIT: alloc <= free_head;
        chm_pkg::S_COMMIT: begin
          if (rq == chm_pkg::REQ_INSERT && !found && alloc < NIL) begin
            status       <= chm_pkg::ST_OK;
            data_out     <= '0;
            total        <= total + CW'(1);
            live_entries <= total + CW'(1);
            if (alloc == free_head) free_head <= node_rlink;
            else never_used <= never_used + PW'(1);
          end else if (rq == chm_pkg::REQ_INSERT) begin
            status       <= found ? chm_pkg::ST_DUP : chm_pkg::ST_FULL;
            data_out     <= '0;
            live_entries <= total;
          end else if (rq == chm_pkg::REQ_DELETE && found) begin
            status       <= chm_pkg::ST_OK;
            data_out     <= '0;
            total        <= (total != '0) ? total - CW'(1) : total;
            live_entries <= (total != '0) ? total - CW'(1) : total;
          end else if (rq == chm_pkg::REQ_SEARCH && found) begin
            status       <= chm_pkg::ST_OK;
            data_out     <= found_data;
            live_entries <= total;
          end else begin
            status       <= chm_pkg::ST_MISSING;
            data_out     <= '0;
            live_entries <= total;
          end
        end
        chm_pkg::S_DONE: begin
          if (rq == chm_pkg::REQ_DELETE && found) free_head <= hit;
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/chm_check.sv]
// port-level checks for the chained hash map, bound to the top level
module chm_check (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // an accepted request makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request not taken");

  // a result ends the request
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after result");

  // results only while a request was in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("stray result");

  // single-cycle result strobe
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result held");

endmodule

bind chained_hash_map_top chm_check u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done)
);
